// ===== rtl/fsed_pkg.sv =====
// fsed_pkg: shared types, constants and helpers of the frame stillness end detector
// no dependencies; used by every rtl file of the block

package fsed_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int FIELD_W     = 24;
  localparam int EXT_W       = (COUNT_WIDTH > FIELD_W) ? COUNT_WIDTH : FIELD_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 72;

  localparam logic [3:0] STILL_RUN_MAX = 4'd15;
  localparam logic [6:0] STEP_MAX      = 7'd64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAX_FRAMES   = 3'd0,
    CFG_MAX_RETRIES  = 3'd1,
    CFG_SAMPLE_STEP  = 3'd2,
    CFG_DIFF_THRESH  = 3'd3,
    CFG_RATIO_DIV    = 3'd4,
    CFG_STILL_NEEDED = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CAPTURE = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    OUT_CONTINUE = 2'd0,
    OUT_RETRY    = 2'd1,
    OUT_END      = 2'd2,
    OUT_LIMIT    = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [15:0] max_frames;
    logic [3:0]  max_retries;
    logic [6:0]  sample_step;
    logic [7:0]  diff_threshold;
    logic [9:0]  ratio_divisor;
    logic [3:0]  still_needed;
  } cfg_t;

  // classified pixel pair passed from front to back
  typedef struct packed {
    logic func;
    logic changed;
    logic line_end;
    logic frame_end;
    logic size_changed;
  } entry_t;

  function automatic logic [FIELD_W-1:0] to_field(input logic [COUNT_WIDTH-1:0] v);
    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] lim;
    ext = EXT_W'(v);
    lim = EXT_W'({FIELD_W{1'b1}});
    return (ext > lim) ? {FIELD_W{1'b1}} : ext[FIELD_W-1:0];
  endfunction

endpackage

// ===== rtl/frame_stillness_end_detector.sv =====
// frame_stillness_end_detector: top level, one pixel pair per cycle unless the queue is full,
// one result per frame end during capture; a frame_end transfer passes a queue slot, then the
// result register; the back counters take one item per cycle while the result is not stalled
// a 4-entry queue decouples input classification from the back; a stalled result stalls it
// reset (rst, synchronous): registers to defaults, counters cleared, idle until begin
// depends on fsed_pkg, fsed_cfg, fsed_front, fsed_queue, fsed_back

module frame_stillness_end_detector (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fsed_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fsed_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // prev_red, prev_green, prev_blue, cur_red, cur_green, cur_blue, line_end, size_changed
  input  logic [fsed_pkg::IN_TDATA_W-1:0]  s_tdata,
  // func
  input  logic                             s_tuser,
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // frame_number, retries_used, changed_samples, total_samples
  output logic [fsed_pkg::OUT_TDATA_W-1:0] m_tdata,
  // outcome
  output logic [1:0]                       m_tuser
);

  fsed_pkg::cfg_t   cfg;
  fsed_pkg::entry_t push_entry;
  fsed_pkg::entry_t q_entry;
  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             q_ready;

  fsed_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fsed_front u_front (
    .s_tdata        (s_tdata),
    .s_tvalid       (s_tvalid),
    .s_tuser        (s_tuser),
    .s_tlast        (s_tlast),
    .s_tready       (s_tready),
    .diff_threshold (cfg.diff_threshold),
    .q_full         (q_full),
    .push           (push),
    .entry          (push_entry)
  );

  fsed_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_entry    (q_entry)
  );

  fsed_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_entry  (q_entry),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== rtl/fsed_cfg.sv =====
// fsed_cfg: configuration register file written through the plain write port
// depends on fsed_pkg

module fsed_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fsed_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fsed_pkg::CFG_DATA_W-1:0]  cfg_data,
  output fsed_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_frames     <= 16'd500;
      cfg.max_retries    <= 4'd3;
      cfg.sample_step    <= 7'd10;
      cfg.diff_threshold <= 8'd5;
      cfg.ratio_divisor  <= 10'd100;
      cfg.still_needed   <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        fsed_pkg::CFG_MAX_FRAMES:   cfg.max_frames     <= cfg_data[15:0];
        fsed_pkg::CFG_MAX_RETRIES:  cfg.max_retries    <= cfg_data[3:0];
        fsed_pkg::CFG_SAMPLE_STEP:  cfg.sample_step    <= cfg_data[6:0];
        fsed_pkg::CFG_DIFF_THRESH:  cfg.diff_threshold <= cfg_data[7:0];
        fsed_pkg::CFG_RATIO_DIV:    cfg.ratio_divisor  <= cfg_data[9:0];
        fsed_pkg::CFG_STILL_NEEDED: cfg.still_needed   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/fsed_front.sv =====
// fsed_front: input side, gray conversion and change classification of each pixel pair
// depends on fsed_pkg; feeds fsed_queue

module fsed_front (
  input  logic [fsed_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic                            s_tvalid,
  input  logic                            s_tuser,
  input  logic                            s_tlast,
  output logic                            s_tready,
  input  logic [7:0]                      diff_threshold,
  input  logic                            q_full,
  output logic                            push,
  output fsed_pkg::entry_t                entry
);

  logic [7:0] prev_gray;
  logic [7:0] cur_gray;
  logic [7:0] diff;

  // sum / 3 as multiply by 683 / 2048, exact for sums up to 765
  function automatic logic [7:0] gray(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = 10'(r) + 10'(g) + 10'(b);
    prod = 20'(sum) * 20'd683;
    return prod[18:11];
  endfunction

  assign prev_gray = gray(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
  assign cur_gray  = gray(s_tdata[31:24], s_tdata[39:32], s_tdata[47:40]);
  assign diff      = (prev_gray > cur_gray) ? (prev_gray - cur_gray) : (cur_gray - prev_gray);

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    entry.func         = s_tuser;
    entry.changed      = diff > diff_threshold;
    entry.line_end     = s_tdata[48];
    entry.frame_end    = s_tlast;
    entry.size_changed = s_tdata[49];
  end

endmodule

// ===== rtl/fsed_queue.sv =====
// fsed_queue: short register queue of classified entries between front and back
// depends on fsed_pkg

module fsed_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fsed_pkg::entry_t push_entry,
  output logic             full,
  output logic             q_valid,
  input  logic             q_ready,
  output fsed_pkg::entry_t q_entry
);

  fsed_pkg::entry_t              slots [fsed_pkg::QUEUE_DEPTH];
  logic [fsed_pkg::QPTR_W-1:0]   wr_ptr;
  logic [fsed_pkg::QPTR_W-1:0]   rd_ptr;
  logic [fsed_pkg::QPTR_W:0]     count;
  logic                          pop;

  assign full    = count == (fsed_pkg::QPTR_W+1)'(fsed_pkg::QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_entry = slots[rd_ptr];
  assign pop     = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/fsed_back.sv =====
// fsed_back: sampling grid, frame counters, stillness decision and result register
// depends on fsed_pkg; takes entries from fsed_queue

module fsed_back (
  input  logic                             clk,
  input  logic                             rst,
  input  fsed_pkg::cfg_t                   cfg,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  fsed_pkg::entry_t                 q_entry,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [fsed_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic [1:0]                       m_tuser
);

  localparam int CW = fsed_pkg::COUNT_WIDTH;

  fsed_pkg::phase_t   state;
  fsed_pkg::phase_t   state_next;
  fsed_pkg::outcome_t outcome;

  logic [15:0]   frame_count, frame_count_next;
  logic [3:0]    retry_count, retry_count_next;
  logic [3:0]    still_run, still_run_next;
  logic [5:0]    col_phase, col_phase_next;
  logic [5:0]    row_phase, row_phase_next;
  logic [CW-1:0] changed_count, changed_count_next;
  logic [CW-1:0] sample_count, sample_count_next;

  logic          pop;
  logic          capture;
  logic          frame_ev;
  logic          is_sample;
  logic [CW-1:0] chg_inc;
  logic [CW-1:0] smp_inc;
  logic [CW+9:0] prod;
  logic          still;
  logic [3:0]    run_upd;
  logic          hit_limit;
  logic          compared;
  logic          end_det;
  logic          do_retry;
  logic [6:0]    step;
  logic [6:0]    col_adv;
  logic [6:0]    row_adv;

  assign q_ready  = !m_tvalid || m_tready;
  assign pop      = q_valid && q_ready;
  assign capture  = state == fsed_pkg::PH_CAPTURE;
  assign frame_ev = pop && !q_entry.func && capture && q_entry.frame_end;

  // decision datapath
  always_comb begin
    step      = (cfg.sample_step == 7'd0) ? 7'd1 :
                (cfg.sample_step > fsed_pkg::STEP_MAX) ? fsed_pkg::STEP_MAX : cfg.sample_step;
    col_adv   = 7'(col_phase) + 7'd1;
    row_adv   = 7'(row_phase) + 7'd1;
    is_sample = (col_phase == 6'd0) && (row_phase == 6'd0);
    chg_inc   = changed_count;
    smp_inc   = sample_count;
    if (is_sample) begin
      if (q_entry.changed && (changed_count != {CW{1'b1}})) begin
        chg_inc = changed_count + 1'b1;
      end
      if (sample_count != {CW{1'b1}}) begin
        smp_inc = sample_count + 1'b1;
      end
    end
    prod      = (CW+10)'(chg_inc) * (CW+10)'(cfg.ratio_divisor);
    still     = prod < (CW+10)'(smp_inc);
    run_upd   = !still ? 4'd0 :
                (still_run < fsed_pkg::STILL_RUN_MAX) ? still_run + 4'd1 : still_run;
    hit_limit = frame_count >= cfg.max_frames;
    compared  = (frame_count != 16'd0) && !q_entry.size_changed && (smp_inc != '0);
    end_det   = compared && (run_upd >= cfg.still_needed);
    do_retry  = end_det && (retry_count < cfg.max_retries);
    if (hit_limit) begin
      outcome = fsed_pkg::OUT_LIMIT;
    end else if (do_retry) begin
      outcome = fsed_pkg::OUT_RETRY;
    end else if (end_det) begin
      outcome = fsed_pkg::OUT_END;
    end else begin
      outcome = fsed_pkg::OUT_CONTINUE;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    if (pop && q_entry.func) begin
      state_next = fsed_pkg::PH_CAPTURE;
    end else if (frame_ev &&
                 (outcome == fsed_pkg::OUT_LIMIT || outcome == fsed_pkg::OUT_END)) begin
      state_next = fsed_pkg::PH_DONE;
    end
  end

  // counters
  always_comb begin
    frame_count_next   = frame_count;
    retry_count_next   = retry_count;
    still_run_next     = still_run;
    col_phase_next     = col_phase;
    row_phase_next     = row_phase;
    changed_count_next = changed_count;
    sample_count_next  = sample_count;
    if (pop && q_entry.func) begin
      frame_count_next   = '0;
      retry_count_next   = '0;
      still_run_next     = '0;
      col_phase_next     = '0;
      row_phase_next     = '0;
      changed_count_next = '0;
      sample_count_next  = '0;
    end else if (pop && capture && !q_entry.frame_end) begin
      changed_count_next = chg_inc;
      sample_count_next  = smp_inc;
      if (q_entry.line_end) begin
        col_phase_next = '0;
        row_phase_next = (row_adv >= step) ? 6'd0 : row_adv[5:0];
      end else begin
        col_phase_next = (col_adv >= step) ? 6'd0 : col_adv[5:0];
      end
    end else if (frame_ev) begin
      col_phase_next     = '0;
      row_phase_next     = '0;
      changed_count_next = '0;
      sample_count_next  = '0;
      if (!hit_limit) begin
        if (frame_count != 16'd0) begin
          if (q_entry.size_changed) begin
            still_run_next = '0;
          end else if (smp_inc != '0) begin
            still_run_next = run_upd;
          end
        end
        if (do_retry) begin
          retry_count_next = retry_count + 4'd1;
          still_run_next   = '0;
        end else if (!end_det) begin
          frame_count_next = frame_count + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fsed_pkg::PH_IDLE;
      frame_count   <= '0;
      retry_count   <= '0;
      still_run     <= '0;
      col_phase     <= '0;
      row_phase     <= '0;
      changed_count <= '0;
      sample_count  <= '0;
    end else begin
      state         <= state_next;
      frame_count   <= frame_count_next;
      retry_count   <= retry_count_next;
      still_run     <= still_run_next;
      col_phase     <= col_phase_next;
      row_phase     <= row_phase_next;
      changed_count <= changed_count_next;
      sample_count  <= sample_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (frame_ev) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_ev) begin
      m_tuser <= outcome;
      m_tdata <= {4'd0, fsed_pkg::to_field(smp_inc), fsed_pkg::to_field(chg_inc),
                  retry_count_next, frame_count_next};
    end
  end

  a_retry_counts: assert property (@(posedge clk) disable iff (rst)
    frame_ev && outcome == fsed_pkg::OUT_RETRY |=>
      retry_count == 4'($past(retry_count) + 4'd1) && still_run == 4'd0)
    else $error("retry did not consume an attempt");

  a_stop_done: assert property (@(posedge clk) disable iff (rst)
    frame_ev && (outcome == fsed_pkg::OUT_END || outcome == fsed_pkg::OUT_LIMIT) |=>
      state == fsed_pkg::PH_DONE)
    else $error("capture did not finish after end or limit");

  a_continue_counts: assert property (@(posedge clk) disable iff (rst)
    frame_ev && outcome == fsed_pkg::OUT_CONTINUE |=>
      frame_count == 16'($past(frame_count) + 16'd1))
    else $error("continued frame not counted");

  a_begin_clears: assert property (@(posedge clk) disable iff (rst)
    pop && q_entry.func |=>
      state == fsed_pkg::PH_CAPTURE && frame_count == 16'd0 && retry_count == 4'd0 &&
      sample_count == '0)
    else $error("begin did not clear the capture");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !frame_ev)
    else $error("result overwritten while stalled");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench of frame_stillness_end_detector, pixel pair stream in,
// one decision out per frame end during capture, checked against a behavioral predictor in this file
// depends on fsed_pkg and the rtl of frame_stillness_end_detector

module tb_top;
  import fsed_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS   = 10;

  typedef enum int {SCENE_SAME, SCENE_NEAR, SCENE_NEW} scene_t;

  typedef struct packed {
    logic       func;
    logic [7:0] pr;
    logic [7:0] pg;
    logic [7:0] pb;
    logic [7:0] cr;
    logic [7:0] cg;
    logic [7:0] cb;
    logic       line_end;
    logic       frame_end;
    logic       size_changed;
  } pixel_item_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [15:0] frame_number;
    logic [3:0]  retries_used;
    logic [23:0] changed_samples;
    logic [23:0] total_samples;
  } decision_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  // prev_red, prev_green, prev_blue, cur_red, cur_green, cur_blue, line_end, size_changed
  logic [IN_TDATA_W-1:0]  s_tdata;
  // func
  logic                   s_tuser;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  // frame_number, retries_used, changed_samples, total_samples
  logic [OUT_TDATA_W-1:0] m_tdata;
  // outcome
  logic [1:0]             m_tuser;

  frame_stillness_end_detector dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  decision_t decision_q[$];
  int        mismatches;
  int        items_live;
  int        quiet_cycles;
  bit        tx_idle_en;
  bit        rx_idle_en;
  bit        idle_allowed;
  bit        hold_req;

  // predictor state
  cfg_t            cfg;
  phase_t          run_ph;
  logic [15:0]     frames_acc;
  logic [3:0]      retries;
  logic [3:0]      still_len;
  int              col_ph;
  int              row_ph;
  longint unsigned chg_cnt;
  longint unsigned smp_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int grid_step();
    if (cfg.sample_step == 0) return 1;
    if (cfg.sample_step > STEP_MAX) return int'(STEP_MAX);
    return int'(cfg.sample_step);
  endfunction

  function automatic int next_phase(input int ph);
    return (ph + 1 >= grid_step()) ? 0 : ph + 1;
  endfunction

  function automatic longint unsigned bump(input longint unsigned v);
    longint unsigned top;
    top = (64'd1 << COUNT_WIDTH) - 1;
    return (v < top) ? v + 1 : v;
  endfunction

  function automatic logic [23:0] clip24(input longint unsigned v);
    return (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
  endfunction

  function automatic void clear_frame_counts();
    col_ph  = 0;
    row_ph  = 0;
    chg_cnt = 0;
    smp_cnt = 0;
  endfunction

  function automatic void reset_predictor();
    cfg.max_frames     = 16'd500;
    cfg.max_retries    = 4'd3;
    cfg.sample_step    = 7'd10;
    cfg.diff_threshold = 8'd5;
    cfg.ratio_divisor  = 10'd100;
    cfg.still_needed   = 4'd2;
    run_ph     = PH_IDLE;
    frames_acc = '0;
    retries    = '0;
    still_len  = '0;
    clear_frame_counts();
  endfunction

  // returns 1 when the item closes a frame and yields a decision
  function automatic bit predict_decision(input pixel_item_t it, output decision_t d);
    int unsigned prev_gray;
    int unsigned cur_gray;
    int unsigned gray_diff;
    bit          end_seen;
    d = '0;
    end_seen = 1'b0;
    if (it.func) begin
      run_ph     = PH_CAPTURE;
      frames_acc = '0;
      retries    = '0;
      still_len  = '0;
      clear_frame_counts();
      return 1'b0;
    end
    if (run_ph != PH_CAPTURE) return 1'b0;
    if (col_ph == 0 && row_ph == 0) begin
      prev_gray = (int'(it.pr) + int'(it.pg) + int'(it.pb)) / 3;
      cur_gray  = (int'(it.cr) + int'(it.cg) + int'(it.cb)) / 3;
      gray_diff = (prev_gray > cur_gray) ? prev_gray - cur_gray : cur_gray - prev_gray;
      if (gray_diff > cfg.diff_threshold) chg_cnt = bump(chg_cnt);
      smp_cnt = bump(smp_cnt);
    end
    if (!it.frame_end) begin
      if (it.line_end) begin
        col_ph = 0;
        row_ph = next_phase(row_ph);
      end else begin
        col_ph = next_phase(col_ph);
      end
      return 1'b0;
    end
    if (frames_acc >= cfg.max_frames) begin
      d.outcome = OUT_LIMIT;
      run_ph    = PH_DONE;
    end else begin
      if (frames_acc > 0) begin
        if (it.size_changed) begin
          still_len = '0;
        end else if (smp_cnt != 0) begin
          if (chg_cnt * longint'(cfg.ratio_divisor) < smp_cnt) begin
            if (still_len < STILL_RUN_MAX) still_len = still_len + 1;
          end else begin
            still_len = '0;
          end
          end_seen = (still_len >= cfg.still_needed);
        end
      end
      if (end_seen) begin
        if (retries < cfg.max_retries) begin
          retries   = retries + 1;
          still_len = '0;
          d.outcome = OUT_RETRY;
        end else begin
          d.outcome = OUT_END;
          run_ph    = PH_DONE;
        end
      end else begin
        frames_acc = frames_acc + 1;
        d.outcome  = OUT_CONTINUE;
      end
    end
    d.frame_number    = frames_acc;
    d.retries_used    = retries;
    d.changed_samples = clip24(chg_cnt);
    d.total_samples   = clip24(smp_cnt);
    clear_frame_counts();
    return 1'b1;
  endfunction

  // result checking
  always @(posedge clk) begin
    decision_t want;
    decision_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.outcome         = outcome_t'(m_tuser);
      got.frame_number    = m_tdata[15:0];
      got.retries_used    = m_tdata[19:16];
      got.changed_samples = m_tdata[43:20];
      got.total_samples   = m_tdata[67:44];
      if (decision_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: outcome %0d frame %0d retries %0d changed %0d total %0d",
                   got.outcome, got.frame_number, got.retries_used,
                   got.changed_samples, got.total_samples);
        mismatches++;
      end else begin
        want = decision_q.pop_front();
        if (got.outcome !== want.outcome || got.frame_number !== want.frame_number ||
            got.retries_used !== want.retries_used ||
            got.changed_samples !== want.changed_samples ||
            got.total_samples !== want.total_samples) begin
          if (mismatches < MAX_REPORTS) begin
            $display("mismatch: expected outcome %0d frame %0d retries %0d changed %0d total %0d",
                     want.outcome, want.frame_number, want.retries_used,
                     want.changed_samples, want.total_samples);
            $display("          got      outcome %0d frame %0d retries %0d changed %0d total %0d",
                     got.outcome, got.frame_number, got.retries_used,
                     got.changed_samples, got.total_samples);
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side ready, random stalls and the long hold-off
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  task automatic send_item(input pixel_item_t it);
    decision_t d;
    @(negedge clk);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = it.func;
    s_tlast  = it.frame_end;
    s_tdata  = {6'b0, it.size_changed, it.line_end, it.cb, it.cg, it.cr, it.pb, it.pg, it.pr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_live++;
    if (predict_decision(it, d)) decision_q.push_back(d);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (decision_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_MAX_FRAMES:   cfg.max_frames     = val[15:0];
      CFG_MAX_RETRIES:  cfg.max_retries    = val[3:0];
      CFG_SAMPLE_STEP:  cfg.sample_step    = val[6:0];
      CFG_DIFF_THRESH:  cfg.diff_threshold = val[7:0];
      CFG_RATIO_DIV:    cfg.ratio_divisor  = val[9:0];
      CFG_STILL_NEEDED: cfg.still_needed   = val[3:0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] nudge(input logic [7:0] b);
    int delta;
    int v;
    delta = $urandom_range(0, 12);
    v = int'(b) + delta - 6;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic pixel_item_t make_pixel(input scene_t sc);
    pixel_item_t p;
    p = '0;
    p.pr = 8'($urandom);
    p.pg = 8'($urandom);
    p.pb = 8'($urandom);
    case (sc)
      SCENE_SAME: begin
        p.cr = p.pr;
        p.cg = p.pg;
        p.cb = p.pb;
      end
      SCENE_NEAR: begin
        p.cr = nudge(p.pr);
        p.cg = nudge(p.pg);
        p.cb = nudge(p.pb);
      end
      default: begin
        p.cr = 8'($urandom);
        p.cg = 8'($urandom);
        p.cb = 8'($urandom);
      end
    endcase
    return p;
  endfunction

  task automatic send_begin();
    pixel_item_t p;
    p = make_pixel(SCENE_NEW);
    p.func         = 1'b1;
    p.line_end     = 1'($urandom);
    p.frame_end    = 1'($urandom);
    p.size_changed = 1'($urandom);
    send_item(p);
  endtask

  task automatic send_frame(input int w, input int h, input scene_t sc, input bit size_chg);
    pixel_item_t p;
    bit          last;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        last = (r == h - 1) && (c == w - 1);
        p = make_pixel(sc);
        p.line_end     = last ? 1'($urandom) : (c == w - 1);
        p.frame_end    = last;
        p.size_changed = last ? size_chg : 1'($urandom);
        send_item(p);
      end
    end
  endtask

  // one pixel frame, all channels flat
  task automatic send_flat_frame(input logic [7:0] pv, input logic [7:0] cv, input bit size_chg);
    pixel_item_t p;
    p = '0;
    p.pr = pv;
    p.pg = pv;
    p.pb = pv;
    p.cr = cv;
    p.cg = cv;
    p.cb = cv;
    p.line_end     = 1'b1;
    p.frame_end    = 1'b1;
    p.size_changed = size_chg;
    send_item(p);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_value(input int lo, input int hi);
    if ($urandom_range(0, 9) == 0) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(lo, hi));
  endfunction

  task automatic randomize_config();
    if ($urandom_range(0, 1)) write_reg(CFG_MAX_FRAMES, pick_value(3, 20));
    if ($urandom_range(0, 1)) write_reg(CFG_MAX_RETRIES, pick_value(0, 3));
    if ($urandom_range(0, 1)) write_reg(CFG_SAMPLE_STEP, pick_value(1, 4));
    if ($urandom_range(0, 1)) write_reg(CFG_DIFF_THRESH, pick_value(0, 20));
    if ($urandom_range(0, 1)) write_reg(CFG_RATIO_DIV, pick_value(1, 20));
    if ($urandom_range(0, 1)) write_reg(CFG_STILL_NEEDED, pick_value(1, 3));
  endtask

  task automatic run_captures(input int quota);
    int          stop_at;
    int          pick;
    int          w;
    int          h;
    scene_t      sc;
    pixel_item_t p;
    stop_at = items_live + quota;
    while (items_live < stop_at) begin
      wait_idle();
      randomize_config();
      tx_idle_en = idle_allowed && ($urandom_range(0, 3) != 0);
      rx_idle_en = idle_allowed && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) != 0) send_begin();
      repeat ($urandom_range(2, 12)) begin
        if ($urandom_range(0, 19) == 0) begin
          w = $urandom_range(60, 72);
          h = $urandom_range(1, 3);
        end else begin
          w = $urandom_range(1, 10);
          h = $urandom_range(1, 6);
        end
        pick = $urandom_range(0, 99);
        sc = (pick < 60) ? SCENE_SAME : (pick < 85) ? SCENE_NEAR : SCENE_NEW;
        if ($urandom_range(0, 19) == 0) begin
          p = make_pixel(SCENE_NEW);
          p.func         = ($urandom_range(0, 3) == 0);
          p.line_end     = 1'($urandom);
          p.frame_end    = 1'($urandom);
          p.size_changed = 1'($urandom);
          send_item(p);
        end
        send_frame(w, h, sc, $urandom_range(0, 9) == 0);
      end
    end
  endtask

  task automatic test_reset_defaults();
    // pixel pairs before any begin are ignored
    send_flat_frame(8'h00, 8'hff, 1'b0);
    send_begin();
    send_frame(11, 11, SCENE_SAME, 1'b0);
    send_frame(11, 11, SCENE_SAME, 1'b0);
    send_frame(11, 11, SCENE_SAME, 1'b0);
    wait_idle();
  endtask

  task automatic test_outcomes();
    write_reg(CFG_SAMPLE_STEP, 16'd1);
    write_reg(CFG_DIFF_THRESH, 16'd0);
    write_reg(CFG_RATIO_DIV, 16'd1);
    write_reg(CFG_STILL_NEEDED, 16'd1);
    write_reg(CFG_MAX_RETRIES, 16'd1);
    write_reg(CFG_MAX_FRAMES, 16'd4);
    send_begin();
    send_flat_frame(8'h00, 8'hff, 1'b0);
    send_flat_frame(8'hff, 8'hff, 1'b0);
    send_flat_frame(8'h80, 8'h80, 1'b0);
    // ignored once the end is confirmed
    send_flat_frame(8'h00, 8'hff, 1'b0);
    send_begin();
    send_flat_frame(8'h00, 8'h00, 1'b0);
    send_flat_frame(8'h00, 8'h00, 1'b1);
    send_flat_frame(8'h00, 8'hff, 1'b0);
    send_flat_frame(8'hff, 8'h00, 1'b0);
    send_flat_frame(8'h00, 8'h00, 1'b0);
    wait_idle();
    // limit on the very first frame
    write_reg(CFG_MAX_FRAMES, 16'd0);
    send_begin();
    send_flat_frame(8'h01, 8'h02, 1'b0);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_MAX_FRAMES, 16'hffff);
    write_reg(CFG_MAX_RETRIES, 16'd15);
    write_reg(CFG_SAMPLE_STEP, 16'd0);
    write_reg(CFG_DIFF_THRESH, 16'd255);
    write_reg(CFG_RATIO_DIV, 16'd0);
    write_reg(CFG_STILL_NEEDED, 16'd0);
    send_begin();
    send_frame(3, 2, SCENE_NEW, 1'b0);
    send_frame(3, 2, SCENE_NEW, 1'b0);
    send_flat_frame(8'hff, 8'h00, 1'b0);
    wait_idle();
  endtask

  task automatic test_grid_step();
    pixel_item_t p;
    write_reg(CFG_SAMPLE_STEP, 16'd127);
    write_reg(CFG_RATIO_DIV, 16'd1000);
    write_reg(CFG_STILL_NEEDED, 16'd15);
    write_reg(CFG_DIFF_THRESH, 16'd0);
    write_reg(CFG_MAX_FRAMES, 16'd100);
    write_reg(CFG_MAX_RETRIES, 16'd2);
    send_begin();
    send_frame(70, 2, SCENE_NEAR, 1'b0);
    send_frame(70, 2, SCENE_SAME, 1'b0);
    wait_idle();
    write_reg(CFG_SAMPLE_STEP, 16'd8);
    for (int i = 0; i < 96; i++) begin
      // shrink the grid mid-frame, both phases sit past the new step
      if (i == 5 * 12 + 6) begin
        wait_idle();
        write_reg(CFG_SAMPLE_STEP, 16'd2);
      end
      p = make_pixel(SCENE_NEAR);
      p.line_end     = (i % 12 == 11);
      p.frame_end    = (i == 95);
      p.size_changed = 1'b0;
      send_item(p);
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    write_reg(CFG_SAMPLE_STEP, 16'd1);
    write_reg(CFG_MAX_FRAMES, 16'hffff);
    write_reg(CFG_STILL_NEEDED, 16'd15);
    write_reg(CFG_RATIO_DIV, 16'd2);
    send_begin();
    hold_req = 1'b1;
    for (int k = 0; k < 40; k++) send_frame(1 + k % 3, 1, SCENE_NEAR, 1'b0);
    wait_idle();
  endtask

  task automatic test_random();
    idle_allowed = 1'b1;
    run_captures(500);
  endtask

  task automatic test_no_idle();
    idle_allowed = 1'b0;
    tx_idle_en   = 1'b0;
    rx_idle_en   = 1'b0;
    run_captures(120);
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = CFG_MAX_FRAMES;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    s_tlast      = 1'b0;
    mismatches   = 0;
    items_live   = 0;
    quiet_cycles = 0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    idle_allowed = 1'b1;
    hold_req     = 1'b0;
    reset_predictor();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_outcomes();
    test_register_extremes();
    test_grid_step();
    test_backpressure();
    test_random();
    test_no_idle();
    wait_idle();

    if (mismatches == 0 && decision_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
